>>> sv/stm_pkg.sv
package stm_pkg;

  localparam int TEMPO_COUNT = 39;
  localparam int LANES = 6;
  localparam int IDX_W = 6;
  localparam int MV_W = 15;
  localparam int RATE_W = 18;
  localparam int LIMIT_W = RATE_W + 6;
  localparam int TICK_W = 19;
  localparam int WIDTH_W = 16;
  localparam int MASK_W = 7;
  localparam int BPM_W = 8;
  localparam int PROD_W = TICK_W + BPM_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic signed [MV_W-1:0] MV_RISE = 15'sd2000;
  localparam logic signed [MV_W-1:0] MV_FALL = 15'sd100;

  localparam logic [IDX_W:0] TEMPO_COUNT_W = (IDX_W + 1)'(TEMPO_COUNT);
  localparam logic [IDX_W-1:0] TEMPO_LAST = IDX_W'(TEMPO_COUNT - 1);
  localparam logic [IDX_W-1:0] TEMPO_RESET =
    (10 < TEMPO_COUNT) ? IDX_W'(10) : IDX_W'(TEMPO_COUNT - 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [IDX_W-1:0] RST_IDX_RESET = IDX_W'(10);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(48);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(48000 * 60);

  // lane order matches the trigger inputs
  typedef enum logic [2:0] {
    LANE_FASTER3 = 3'd0,
    LANE_FASTER2 = 3'd1,
    LANE_FASTER1 = 3'd2,
    LANE_SLOWER1 = 3'd3,
    LANE_RESET   = 3'd4,
    LANE_PLAY    = 3'd5
  } lane_t;

  localparam int OUT_EN_BIT = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_RESET_INDEX = 2'd1,
    REG_PULSE_WIDTH = 2'd2,
    REG_ENABLE_MASK = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } beat_ctrl_t;

  localparam logic [BPM_W-1:0] BPM_TABLE [0:63] = '{
    8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd54, 8'd56, 8'd58,
    8'd60, 8'd63, 8'd66, 8'd69, 8'd72, 8'd76, 8'd80, 8'd84, 8'd88, 8'd92,
    8'd96, 8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd126, 8'd132,
    8'd138, 8'd144, 8'd152, 8'd160, 8'd168, 8'd176, 8'd184, 8'd192, 8'd200,
    8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208,
    8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208,
    8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208, 8'd208
  };

  // index is always below the tempo count, so one subtract wraps it
  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [1:0] n);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + {{(IDX_W - 1){1'b0}}, n};
    if (sum >= TEMPO_COUNT_W) begin
      sum = sum - TEMPO_COUNT_W;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> sv/stm_trig_lane.sv
module stm_trig_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             enable,
  input  logic signed [stm_pkg::MV_W-1:0]  mv,
  output logic                             fire
);

  logic level_r;
  logic level_nxt;

  // schmitt trigger: rises at 2 V, falls at 0.1 V
  always_comb begin
    level_nxt = level_r;
    fire = 1'b0;
    if (enable) begin
      if (level_r) begin
        if (mv <= stm_pkg::MV_FALL) begin
          level_nxt = 1'b0;
        end
      end else if (mv >= stm_pkg::MV_RISE) begin
        level_nxt = 1'b1;
        fire = accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
    end else if (accept) begin
      level_r <= level_nxt;
    end
  end

endmodule

>>> sv/stm_merge.sv
module stm_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [stm_pkg::LANES-1:0]       fire,
  input  logic [stm_pkg::IDX_W-1:0]       reset_index,
  output logic [stm_pkg::IDX_W-1:0]       tempo_index,
  output logic                            run
);

  logic [stm_pkg::IDX_W-1:0] tempo_r;
  logic [stm_pkg::IDX_W-1:0] tempo_nxt;
  logic                      run_r;
  logic                      run_nxt;
  logic [stm_pkg::IDX_W-1:0] load_idx;

  assign load_idx = ({1'b0, reset_index} < stm_pkg::TEMPO_COUNT_W) ?
                    reset_index : stm_pkg::TEMPO_LAST;

  // lanes apply in input order, each on the index left by the one before
  always_comb begin
    tempo_nxt = tempo_r;
    if (fire[stm_pkg::LANE_FASTER3]) begin
      tempo_nxt = stm_pkg::step_up(tempo_nxt, 2'd3);
    end
    if (fire[stm_pkg::LANE_FASTER2]) begin
      tempo_nxt = stm_pkg::step_up(tempo_nxt, 2'd2);
    end
    if (fire[stm_pkg::LANE_FASTER1]) begin
      tempo_nxt = stm_pkg::step_up(tempo_nxt, 2'd1);
    end
    if (fire[stm_pkg::LANE_SLOWER1]) begin
      tempo_nxt = (tempo_nxt == '0) ? stm_pkg::TEMPO_LAST : tempo_nxt - 1'b1;
    end
    if (fire[stm_pkg::LANE_RESET]) begin
      tempo_nxt = load_idx;
    end
    run_nxt = run_r ^ fire[stm_pkg::LANE_PLAY];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= stm_pkg::TEMPO_RESET;
      run_r   <= 1'b0;
    end else if (accept) begin
      tempo_r <= tempo_nxt;
      run_r   <= run_nxt;
    end
  end

  assign tempo_index = tempo_r;
  assign run = run_r;

endmodule

>>> sv/stm_beat.sv
module stm_beat (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stm_pkg::beat_ctrl_t               ctrl,
  input  logic [stm_pkg::IDX_W-1:0]         tempo_index,
  input  logic [stm_pkg::LIMIT_W-1:0]       limit,
  input  logic [stm_pkg::WIDTH_W-1:0]       pulse_width,
  output logic                              level
);

  logic [stm_pkg::TICK_W-1:0]  tick_r;
  logic [stm_pkg::TICK_W-1:0]  tick_nxt;
  logic [stm_pkg::WIDTH_W-1:0] left_r;
  logic [stm_pkg::WIDTH_W-1:0] left_nxt;
  logic                        level_r;
  logic                        level_nxt;
  logic [stm_pkg::TICK_W-1:0]  tick_inc;
  logic [stm_pkg::PROD_W-1:0]  prod;
  logic [stm_pkg::WIDTH_W-1:0] armed;
  logic                        hit;
  logic                        beat;

  assign tick_inc = tick_r + 1'b1;
  assign prod = stm_pkg::PROD_W'(tick_inc) *
                stm_pkg::PROD_W'(stm_pkg::BPM_TABLE[tempo_index]);
  assign hit = prod >= stm_pkg::PROD_W'(limit);
  // first tick after a restart also beats
  assign beat = hit || (tick_inc == stm_pkg::TICK_W'(1));
  assign armed = (beat && (pulse_width > left_r)) ? pulse_width : left_r;

  always_comb begin
    tick_nxt = tick_r;
    left_nxt = left_r;
    level_nxt = level_r;
    if (ctrl.advance) begin
      tick_nxt = hit ? '0 : tick_inc;
      if (armed != '0) begin
        left_nxt = armed - 1'b1;
        level_nxt = 1'b1;
      end else begin
        left_nxt = armed;
        level_nxt = 1'b0;
      end
    end
    if (ctrl.clear) begin
      tick_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      left_r  <= '0;
      level_r <= 1'b0;
    end else begin
      tick_r  <= tick_nxt;
      left_r  <= left_nxt;
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

  a_clear_zeroes_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (tick_r == '0))
    else $error("tick counter not cleared by play toggle");

  a_level_needs_left: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.advance && (left_r == '0) && !beat) |=> !level_r)
    else $error("pulse level high with nothing armed");

endmodule

>>> sv/stepped_tempo_metronome.sv
// channel | direction | handshake              | payload
// in      | request   | in_valid / in_ready    | six trigger voltages, 15 bit signed mV
// out     | result    | out_valid / out_ready  | pulse_out, tempo_now, playing
// cfg     | write     | cfg_wr_en              | cfg_addr, cfg_wdata
//
// one request per cycle while no result is stalled; each result is registered and appears the cycle after accept
// six schmitt lanes run in parallel, the merge chain and beat compare are combinational
// in_ready stays high while the result register is empty or being taken
// synchronous active-low reset: tempo 10, stopped, all trigger levels high
// a stalled result blocks new requests until out_ready
module stepped_tempo_metronome (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [stm_pkg::MV_W-1:0]     in_faster3_mv,
  input  logic signed [stm_pkg::MV_W-1:0]     in_faster2_mv,
  input  logic signed [stm_pkg::MV_W-1:0]     in_faster1_mv,
  input  logic signed [stm_pkg::MV_W-1:0]     in_slower1_mv,
  input  logic signed [stm_pkg::MV_W-1:0]     in_tempo_reset_mv,
  input  logic signed [stm_pkg::MV_W-1:0]     in_play_toggle_mv,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_pulse_out,
  output logic [stm_pkg::IDX_W-1:0]           out_tempo_now,
  output logic                                out_playing,
  input  logic                                cfg_wr_en,
  input  logic [stm_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [stm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [stm_pkg::LIMIT_W-1:0] limit_r;
  logic [stm_pkg::IDX_W-1:0]   rst_idx_r;
  logic [stm_pkg::WIDTH_W-1:0] width_r;
  logic [stm_pkg::MASK_W-1:0]  mask_r;
  logic [stm_pkg::LIMIT_W-1:0] limit_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        accept;
  logic                        run;
  logic [stm_pkg::IDX_W-1:0]   tempo_index;
  logic [stm_pkg::LANES-1:0]   fire;
  logic signed [stm_pkg::MV_W-1:0] lane_mv [stm_pkg::LANES];
  stm_pkg::beat_ctrl_t         beat_ctrl;

  // 60 * rate as shift and subtract, kept with the register
  assign limit_nxt = (stm_pkg::LIMIT_W'(cfg_wdata) << 6) - (stm_pkg::LIMIT_W'(cfg_wdata) << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= stm_pkg::LIMIT_RESET;
      rst_idx_r <= stm_pkg::RST_IDX_RESET;
      width_r   <= stm_pkg::WIDTH_RESET;
      mask_r    <= '0;
    end else if (cfg_wr_en) begin
      case (stm_pkg::reg_idx_t'(cfg_addr))
        stm_pkg::REG_SAMPLE_RATE: limit_r   <= limit_nxt;
        stm_pkg::REG_RESET_INDEX: rst_idx_r <= cfg_wdata[stm_pkg::IDX_W-1:0];
        stm_pkg::REG_PULSE_WIDTH: width_r   <= cfg_wdata[stm_pkg::WIDTH_W-1:0];
        stm_pkg::REG_ENABLE_MASK: mask_r    <= cfg_wdata[stm_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;
  assign out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign lane_mv[stm_pkg::LANE_FASTER3] = in_faster3_mv;
  assign lane_mv[stm_pkg::LANE_FASTER2] = in_faster2_mv;
  assign lane_mv[stm_pkg::LANE_FASTER1] = in_faster1_mv;
  assign lane_mv[stm_pkg::LANE_SLOWER1] = in_slower1_mv;
  assign lane_mv[stm_pkg::LANE_RESET]   = in_tempo_reset_mv;
  assign lane_mv[stm_pkg::LANE_PLAY]    = in_play_toggle_mv;

  for (genvar g = 0; g < stm_pkg::LANES; g++) begin : g_lane
    stm_trig_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .accept (accept),
      .enable (mask_r[g]),
      .mv     (lane_mv[g]),
      .fire   (fire[g])
    );
  end

  stm_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .fire        (fire),
    .reset_index (rst_idx_r),
    .tempo_index (tempo_index),
    .run         (run)
  );

  // beat uses the index and run flag from before this request's triggers
  assign beat_ctrl.advance = accept && run && mask_r[stm_pkg::OUT_EN_BIT];
  assign beat_ctrl.clear = fire[stm_pkg::LANE_PLAY];

  stm_beat u_beat (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (beat_ctrl),
    .tempo_index (tempo_index),
    .limit       (limit_r),
    .pulse_width (width_r),
    .level       (out_pulse_out)
  );

  assign out_valid = out_valid_r;
  assign out_tempo_now = tempo_index;
  assign out_playing = run;

  a_tempo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, out_tempo_now} < stm_pkg::TEMPO_COUNT_W)
    else $error("tempo index out of range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while result stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request gave no result");

  a_state_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_playing) |-> $past(accept))
    else $error("run flag changed without a request");

endmodule
